// File: src/dotb_pkg.sv
`default_nettype none
package dotb_pkg;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_RESET   = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;
    localparam logic [2:0] OP_COLLECT = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INACTIVE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic [31:0] WINDOW_RESET = 32'd3600000;  // one hour in ms
    localparam int          MAX_OUT      = 16;
    localparam int          CNT_W        = $clog2(MAX_OUT + 1);

    typedef struct packed {
        logic [31:0] period;
        logic [47:0] deadline;
        logic        rep;
        logic [15:0] tag;
    } t_rec;

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

endpackage
`default_nettype wire

// File: src/deadline_ordered_timer_bank.sv
// Timer bank with a single sequencer and one compare unit; each operation scans the slots in order.
// Cancel needs no scan. Refresh and reset scan at most once; add scans twice, once when full.
// Query scans once. Collect scans once and stops there on an empty bank or when nothing is due,
// else scans once per expired timer and emits each result, with a closing scan under 16 results.
// One request at a time; s_axis_tready is high only while idle, results wait in the output reg.
// Synchronous active-low reset clears slot valid bits, wake mark and time; window back to 1 h.
`default_nettype none
module deadline_ordered_timer_bank
    import dotb_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // slot[3:0] interval_ms[35:4] repeat_req[36] restart_from_now[37]
    // user_tag[53:38] now_ms[101:54]
    input  wire logic [103:0] s_axis_tdata,
    // operation[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_slot[3:0] expired_tag[19:4] remaining_ms[67:20] wake_needed[68]
    output logic [71:0]       m_axis_tdata,
    // status[1:0]
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DONE, S_RD, S_RDW, S_RSTW, S_CROLL, S_CNEXT, S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        PH_FREE, PH_WAKE, PH_QUERY, PH_CFIRST, PH_CSEL
    } t_phase;

    t_state r_state, r_after;
    t_phase r_phase;

    t_rec r_mem [SLOTS];
    t_rec r_rd;

    logic [SLOTS-1:0] r_active, r_taken;
    logic [47:0]      r_prev;
    logic             r_wake_sent;
    logic [31:0]      r_window;

    logic [2:0]  r_op;
    logic [3:0]  r_slot;
    logic [31:0] r_ival;
    logic        r_rep, r_fromnow;
    logic [15:0] r_tag;
    logic [47:0] r_now;

    logic [SW:0]   r_idx;
    logic          r_rd_vld;
    logic [SW-1:0] r_rd_idx;
    logic          r_best_found, r_free_found;
    logic [SW-1:0] r_best_idx, r_free, r_wslot;
    t_rec          r_best_rec, r_cur;
    logic [47:0]   r_start;
    logic [48:0]   r_pdiff;
    logic          r_roll;
    logic [CNT_W-1:0] r_cnt;
    logic          r_have_pend;
    logic [SW-1:0] r_p_slot;
    logic [15:0]   r_p_tag;

    logic [1:0]  r_e_status, r_o_status;
    logic [3:0]  r_e_slot, r_o_slot;
    logic [15:0] r_e_tag, r_o_tag;
    logic [47:0] r_e_rem, r_o_rem;
    logic        r_e_wake, r_o_wake, r_e_last, r_o_last, r_o_valid;

    logic          w_accept, w_out_free, w_svalid, w_re, w_we;
    logic [SW-1:0] w_sidx, w_ra, w_wa;
    t_rec          w_wd;
    logic          w_cand, w_better, w_due, w_wake;
    logic [48:0]   w_qdiff;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_o_valid || m_axis_tready;
    assign w_svalid      = (32'(r_slot) < SLOTS);
    assign w_sidx        = SW'(r_slot);

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {3'b0, r_o_wake, r_o_rem, r_o_tag, r_o_slot};
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tlast  = r_o_last;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : r_window;

    // scan compare
    assign w_due    = (r_rd.deadline <= r_now);
    assign w_cand   = r_active[r_rd_idx] && !r_taken[r_rd_idx]
                      && ((r_phase != PH_CSEL) || r_roll || w_due);
    assign w_better = !r_best_found || (r_rd.deadline < r_best_rec.deadline);
    assign w_qdiff  = {1'b0, r_best_rec.deadline} - {1'b0, r_now};
    assign w_wake   = r_best_found && (r_best_idx == r_wslot) && !r_wake_sent;

    assign w_re = ((r_state == S_SCAN) && (r_idx < (SW+1)'(SLOTS))) || (r_state == S_RD);
    assign w_ra = (r_state == S_SCAN) ? r_idx[SW-1:0] : w_sidx;

    always_comb begin
        w_we = 1'b0;
        w_wa = w_sidx;
        w_wd = r_rd;
        unique case (r_state)
            S_DONE: begin
                if (r_phase == PH_FREE && r_free_found) begin
                    w_we = 1'b1;
                    w_wa = r_free;
                    w_wd = '{period: r_ival, deadline: sat_add(r_now, r_ival),
                             rep: r_rep, tag: r_tag};
                end else if (r_phase == PH_CSEL && r_best_found && r_best_rec.rep) begin
                    w_we = 1'b1;
                    w_wa = r_best_idx;
                    w_wd = r_best_rec;
                    w_wd.deadline = sat_add(r_now, r_best_rec.period);
                end
            end
            S_RDW: begin
                if (r_op == OP_REFRESH && r_active[w_sidx]) begin
                    w_we = 1'b1;
                    w_wd.deadline = sat_add(r_now, r_rd.period);
                end
            end
            S_RSTW: begin
                w_we = 1'b1;
                w_wd = '{period: r_ival, deadline: sat_add(r_start, r_ival),
                         rep: r_cur.rep, tag: r_cur.tag};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_re) r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_after      <= S_IDLE;
            r_phase      <= PH_FREE;
            r_active     <= '0;
            r_taken      <= '0;
            r_prev       <= '0;
            r_wake_sent  <= 1'b0;
            r_window     <= WINDOW_RESET;
            r_o_valid    <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_free_found <= 1'b0;
            r_have_pend  <= 1'b0;
            r_cnt        <= '0;
            r_roll       <= 1'b0;
        end else begin
            if (psel && penable && pwrite && !paddr[2]) r_window <= pwdata;

            if (r_state == S_EMIT && w_out_free) begin
                r_o_valid  <= 1'b1;
                r_o_status <= r_e_status;
                r_o_slot   <= r_e_slot;
                r_o_tag    <= r_e_tag;
                r_o_rem    <= r_e_rem;
                r_o_wake   <= r_e_wake;
                r_o_last   <= r_e_last;
                r_state    <= r_after;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end

            r_rd_vld <= w_re && (r_state == S_SCAN);
            r_rd_idx <= r_idx[SW-1:0];

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op       <= s_axis_tuser;
                        r_slot     <= s_axis_tdata[3:0];
                        r_ival     <= s_axis_tdata[35:4];
                        r_rep      <= s_axis_tdata[36];
                        r_fromnow  <= s_axis_tdata[37];
                        r_tag      <= s_axis_tdata[53:38];
                        r_now      <= s_axis_tdata[101:54];
                        r_e_status <= ST_INACTIVE;
                        r_e_slot   <= '0;
                        r_e_tag    <= '0;
                        r_e_rem    <= '0;
                        r_e_wake   <= 1'b0;
                        r_e_last   <= 1'b1;
                        r_after    <= S_IDLE;
                        r_idx        <= '0;
                        r_best_found <= 1'b0;
                        r_free_found <= 1'b0;
                        r_taken      <= '0;
                        unique case (s_axis_tuser)
                            OP_ADD: begin
                                r_phase <= PH_FREE;
                                r_state <= S_SCAN;
                            end
                            OP_CANCEL, OP_REFRESH, OP_RESET: r_state <= S_RD;
                            OP_QUERY: begin
                                r_wake_sent <= 1'b0;
                                r_phase     <= PH_QUERY;
                                r_state     <= S_SCAN;
                            end
                            OP_COLLECT: begin
                                r_phase <= PH_CFIRST;
                                r_state <= S_SCAN;
                            end
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end

                S_SCAN: begin
                    if (r_idx < (SW+1)'(SLOTS)) r_idx <= r_idx + 1'b1;
                    if (r_rd_vld) begin
                        if (w_cand && w_better) begin
                            r_best_found <= 1'b1;
                            r_best_idx   <= r_rd_idx;
                            r_best_rec   <= r_rd;
                        end
                        if (!r_active[r_rd_idx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free       <= r_rd_idx;
                        end
                        if (r_rd_idx == SW'(SLOTS - 1)) r_state <= S_DONE;
                    end
                end

                S_RD: begin
                    // cancel needs no record; refresh and reset read the slot
                    if (!w_svalid) begin
                        r_state <= S_EMIT;
                    end else if (r_op == OP_CANCEL) begin
                        if (r_active[w_sidx]) begin
                            r_active[w_sidx] <= 1'b0;
                            r_e_status       <= ST_OK;
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_RDW;
                    end
                end

                S_RDW: begin
                    r_idx        <= '0;
                    r_best_found <= 1'b0;
                    r_wslot      <= w_sidx;
                    r_phase      <= PH_WAKE;
                    if (r_op == OP_REFRESH) begin
                        r_state <= r_active[w_sidx] ? S_SCAN : S_EMIT;
                    end else if (r_ival == r_rd.period && !r_fromnow) begin
                        r_e_status <= ST_OK;
                        r_state    <= S_EMIT;
                    end else if (!r_active[w_sidx]) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_cur <= r_rd;
                        if (r_fromnow)
                            r_start <= r_now;
                        else if (r_rd.deadline >= {16'b0, r_rd.period})
                            r_start <= r_rd.deadline - {16'b0, r_rd.period};
                        else
                            r_start <= '0;
                        r_state <= S_RSTW;
                    end
                end

                S_RSTW: r_state <= S_SCAN;

                S_DONE: begin
                    r_idx        <= '0;
                    r_best_found <= 1'b0;
                    unique case (r_phase)
                        PH_FREE: begin
                            if (!r_free_found) begin
                                r_e_status <= ST_FULL;
                                r_state    <= S_EMIT;
                            end else begin
                                r_active[r_free] <= 1'b1;
                                r_wslot          <= r_free;
                                r_phase          <= PH_WAKE;
                                r_state          <= S_SCAN;
                            end
                        end
                        PH_WAKE: begin
                            r_e_status <= ST_OK;
                            r_e_wake   <= w_wake;
                            if (w_wake) r_wake_sent <= 1'b1;
                            if (r_op == OP_ADD) r_e_slot <= 4'(r_wslot);
                            r_state <= S_EMIT;
                        end
                        PH_QUERY: begin
                            if (!r_best_found) begin
                                r_e_rem <= '1;
                            end else begin
                                r_e_status <= ST_OK;
                                r_e_rem    <= w_qdiff[48] ? 48'd0 : w_qdiff[47:0];
                            end
                            r_state <= S_EMIT;
                        end
                        PH_CFIRST: begin
                            if (!r_best_found) begin
                                r_e_status <= ST_NONE;
                                r_state    <= S_EMIT;
                            end else begin
                                r_pdiff      <= {1'b0, r_prev} - {1'b0, r_now};
                                r_state      <= S_CROLL;
                            end
                        end
                        PH_CSEL: begin
                            if (!r_best_found) begin
                                r_e_status <= ST_OK;
                                r_e_slot   <= 4'(r_p_slot);
                                r_e_tag    <= r_p_tag;
                                r_e_last   <= 1'b1;
                                r_after    <= S_IDLE;
                                r_state    <= S_EMIT;
                            end else begin
                                // re-arm or free now; taken keeps it out of later scans
                                r_taken[r_best_idx] <= 1'b1;
                                if (!r_best_rec.rep) r_active[r_best_idx] <= 1'b0;
                                r_cnt       <= r_cnt + 1'b1;
                                r_p_slot    <= r_best_idx;
                                r_p_tag     <= r_best_rec.tag;
                                r_have_pend <= 1'b1;
                                if (r_have_pend) begin
                                    r_e_status <= ST_OK;
                                    r_e_slot   <= 4'(r_p_slot);
                                    r_e_tag    <= r_p_tag;
                                    r_e_last   <= 1'b0;
                                    r_after    <= S_CNEXT;
                                    r_state    <= S_EMIT;
                                end else begin
                                    r_state <= S_CNEXT;
                                end
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end

                S_CROLL: begin
                    r_prev      <= r_now;
                    r_roll      <= !r_pdiff[48] && (r_pdiff[47:0] > {16'b0, r_window});
                    r_cnt       <= '0;
                    r_have_pend <= 1'b0;
                    r_best_found <= 1'b0;
                    if (!(!r_pdiff[48] && (r_pdiff[47:0] > {16'b0, r_window}))
                        && (r_best_rec.deadline > r_now)) begin
                        r_e_status <= ST_NONE;
                        r_state    <= S_EMIT;
                    end else begin
                        r_phase <= PH_CSEL;
                        r_state <= S_SCAN;
                    end
                end

                S_CNEXT: begin
                    r_idx        <= '0;
                    r_best_found <= 1'b0;
                    if (r_cnt == CNT_W'(MAX_OUT)) begin
                        r_e_status <= ST_OK;
                        r_e_slot   <= 4'(r_p_slot);
                        r_e_tag    <= r_p_tag;
                        r_e_last   <= 1'b1;
                        r_after    <= S_IDLE;
                        r_state    <= S_EMIT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end

                S_EMIT: ;

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/dotb_checker.sv
`default_nettype none
module dotb_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [71:0]  m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser,
    input wire logic         m_axis_tlast
);

    // one request in flight: busy right after taking one
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a request while busy");

    // only ok collect results continue a run
    a_nonlast_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == 2'd0)
        else $error("non-final result with error status");

    a_nonlast_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[68:20] == 49'd0)
        else $error("non-final result carries query or wake data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind deadline_ordered_timer_bank dotb_checker u_dotb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
